[hdl/slaw_pkg.sv]
// ----------------------------------------------------------------------------
// slaw_pkg
// Shared types and constants of the slot lease allocator with watchdog.
// ----------------------------------------------------------------------------
package slaw_pkg;

	localparam int SLOTS_DEF      = 8;
	localparam int WAIT_DEPTH_DEF = 64;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 31;
	localparam int IN_DW  = 16;
	localparam int IN_UW  = 2;
	localparam int OUT_DW = 88;
	localparam int OUT_UW = 3;

	localparam logic [3:0]  SLOTS_IN_USE_RST = 4'd8;
	localparam logic [30:0] ACQ_TIMEOUT_RST  = 31'd30000;
	localparam logic [6:0]  MAX_WAITERS_RST  = 7'd64;
	localparam logic [30:0] STUCK_THRESH_RST = 31'd0;

	typedef enum logic [1:0] {
		MODE_ACQUIRE,
		MODE_RELEASE,
		MODE_TICK,
		MODE_CHECK
	} mode_t;

	typedef enum logic [1:0] {
		REG_SLOTS_IN_USE,
		REG_ACQ_TIMEOUT,
		REG_MAX_WAITERS,
		REG_STUCK_THRESH
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_GRANTED,
		KIND_SHED,
		KIND_PARKED,
		KIND_TIMED_OUT,
		KIND_RELEASED,
		KIND_BAD_RELEASE,
		KIND_STUCK,
		KIND_STATUS
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_ACQ,
		OP_REL,
		OP_EMIT_PEND,
		OP_EMIT_GRANT,
		OP_T_INC,
		OP_T_RD,
		OP_T1_EV,
		OP_T2_START,
		OP_T2_EV,
		OP_C1,
		OP_C2,
		OP_C_STAT
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACQ,
		ST_REL,
		ST_EMIT,
		ST_GRANT,
		ST_T_INC,
		ST_T1_RD,
		ST_T1_EV,
		ST_T1_END,
		ST_T2_RD,
		ST_T2_EV,
		ST_C1,
		ST_C2,
		ST_C_STAT
	} state_t;

	typedef struct packed {
		mode_t in_mode;
		logic  out_free;
		logic  wq_nonempty;
		logic  grant_pend;
		logic  tick_done;
		logic  due;
		logic  due_zero;
		logic  slot_done;
		logic  hit;
	} dp_status_t;

endpackage

[hdl/slaw_ctrl.sv]
// ----------------------------------------------------------------------------
// slaw_ctrl
// Sequencer: walks each transaction through update, scan and result steps.
// ----------------------------------------------------------------------------
module slaw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  slaw_pkg::dp_status_t st,
	output slaw_pkg::dp_op_t     op
);

	slaw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slaw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			slaw_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (st.in_mode)
						slaw_pkg::MODE_ACQUIRE: state_d = slaw_pkg::ST_ACQ;
						slaw_pkg::MODE_RELEASE: state_d = slaw_pkg::ST_REL;
						slaw_pkg::MODE_TICK:    state_d = slaw_pkg::ST_T_INC;
						default:                state_d = slaw_pkg::ST_C1;
					endcase
				end
			end
			slaw_pkg::ST_ACQ:   state_d = slaw_pkg::ST_EMIT;
			slaw_pkg::ST_REL:   state_d = slaw_pkg::ST_EMIT;
			slaw_pkg::ST_EMIT: begin
				if (st.out_free)
					state_d = st.grant_pend ? slaw_pkg::ST_GRANT : slaw_pkg::ST_IDLE;
			end
			slaw_pkg::ST_GRANT: begin
				if (st.out_free) state_d = slaw_pkg::ST_IDLE;
			end
			slaw_pkg::ST_T_INC:
				state_d = st.wq_nonempty ? slaw_pkg::ST_T1_RD : slaw_pkg::ST_IDLE;
			slaw_pkg::ST_T1_RD: state_d = slaw_pkg::ST_T1_EV;
			slaw_pkg::ST_T1_EV:
				state_d = st.tick_done ? slaw_pkg::ST_T1_END : slaw_pkg::ST_T1_RD;
			slaw_pkg::ST_T1_END:
				state_d = st.due_zero ? slaw_pkg::ST_IDLE : slaw_pkg::ST_T2_RD;
			slaw_pkg::ST_T2_RD: state_d = slaw_pkg::ST_T2_EV;
			slaw_pkg::ST_T2_EV: begin
				if (!st.due || st.out_free)
					state_d = st.tick_done ? slaw_pkg::ST_IDLE : slaw_pkg::ST_T2_RD;
			end
			slaw_pkg::ST_C1: begin
				if (st.slot_done) state_d = slaw_pkg::ST_C2;
			end
			slaw_pkg::ST_C2: begin
				if ((!st.hit || st.out_free) && st.slot_done) state_d = slaw_pkg::ST_C_STAT;
			end
			slaw_pkg::ST_C_STAT: begin
				if (st.out_free) state_d = slaw_pkg::ST_IDLE;
			end
			default: state_d = slaw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		op       = slaw_pkg::OP_NONE;
		case (state_q)
			slaw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = slaw_pkg::OP_ACCEPT;
			end
			slaw_pkg::ST_ACQ:   op = slaw_pkg::OP_ACQ;
			slaw_pkg::ST_REL:   op = slaw_pkg::OP_REL;
			slaw_pkg::ST_EMIT: begin
				if (st.out_free) op = slaw_pkg::OP_EMIT_PEND;
			end
			slaw_pkg::ST_GRANT: begin
				if (st.out_free) op = slaw_pkg::OP_EMIT_GRANT;
			end
			slaw_pkg::ST_T_INC: op = slaw_pkg::OP_T_INC;
			slaw_pkg::ST_T1_RD: op = slaw_pkg::OP_T_RD;
			slaw_pkg::ST_T1_EV: op = slaw_pkg::OP_T1_EV;
			slaw_pkg::ST_T1_END: begin
				if (!st.due_zero) op = slaw_pkg::OP_T2_START;
			end
			slaw_pkg::ST_T2_RD: op = slaw_pkg::OP_T_RD;
			slaw_pkg::ST_T2_EV: begin
				if (!st.due || st.out_free) op = slaw_pkg::OP_T2_EV;
			end
			slaw_pkg::ST_C1:    op = slaw_pkg::OP_C1;
			slaw_pkg::ST_C2: begin
				if (!st.hit || st.out_free) op = slaw_pkg::OP_C2;
			end
			slaw_pkg::ST_C_STAT: begin
				if (st.out_free) op = slaw_pkg::OP_C_STAT;
			end
			default: op = slaw_pkg::OP_NONE;
		endcase
	end

endmodule

[hdl/slaw_dp.sv]
// ----------------------------------------------------------------------------
// slaw_dp
// Datapath: configuration, free stack, lease table, waiter queue memory,
// millisecond clock, stuck counter and the output register.
// ----------------------------------------------------------------------------
module slaw_dp #(
	parameter int SLOTS      = slaw_pkg::SLOTS_DEF,
	parameter int WAIT_DEPTH = slaw_pkg::WAIT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slaw_pkg::dp_op_t              op,
	output slaw_pkg::dp_status_t          st,
	input  logic                          cfg_we,
	input  logic [slaw_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [slaw_pkg::CFG_DW-1:0]   cfg_data,
	input  logic [slaw_pkg::IN_DW-1:0]    in_tdata,
	input  logic [slaw_pkg::IN_UW-1:0]    in_tuser,
	input  logic                          out_tready,
	output logic                          out_tvalid,
	output logic [slaw_pkg::OUT_DW-1:0]   out_tdata,
	output logic [slaw_pkg::OUT_UW-1:0]   out_tuser,
	output logic                          out_tlast
);

	localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TW  = $clog2(SLOTS + 1);
	localparam int PW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CW  = $clog2(WAIT_DEPTH + 1);

	function automatic logic [TW-1:0] eff_of(input logic [3:0] v);
		return ({28'd0, v} >= 32'(SLOTS)) ? TW'(SLOTS) : TW'(v);
	endfunction

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (32'(p) == 32'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [3:0]  slots_q;
	logic [30:0] tmo_q;
	logic [6:0]  maxw_q;
	logic [30:0] thr_q;

	// pool
	logic [SIW-1:0] stack_q [SLOTS];
	logic [TW-1:0]  top_q;
	logic [SLOTS-1:0] leased_q;
	logic [SLOTS-1:0] rep_q;
	logic [31:0]    stamp_q [SLOTS];
	logic [31:0]    cnt_q;
	logic [31:0]    now_q;

	// waiter queue: {forever, deadline, tag}
	logic [40:0]    mem [WAIT_DEPTH];
	logic [40:0]    rdata_q;
	logic [PW-1:0]  head_q, tail_q, rp_q, wp_q;
	logic [CW-1:0]  wcnt_q, len_q, tidx_q, due_q, emit_q;

	// transaction payload
	logic [2:0]     slot_in_q;
	logic [7:0]     tag_in_q;
	logic [SIW-1:0] sidx_q;
	logic [31:0]    oldest_q;
	slaw_pkg::kind_t pkind_q;
	logic [2:0]     pslot_q;
	logic [7:0]     ptag_q;
	logic           plast_q;
	logic           grant_q;
	logic [2:0]     gslot_q;
	logic [7:0]     gtag_q;

	// output register
	logic           ov_q;
	slaw_pkg::kind_t okind_q;
	logic [2:0]     oslot_q;
	logic [7:0]     otag_q;
	logic [31:0]    oage_q;
	logic [31:0]    ocnt_q;
	logic [3:0]     ofree_q;
	logic [6:0]     owait_q;
	logic           olast_q;

	// combinational
	logic [TW-1:0]  eff;
	logic [TW-1:0]  tm1;
	logic [SIW-1:0] pop_slot;
	logic [SIW-1:0] top_idx;
	logic [SIW-1:0] rel_idx;
	logic           rel_bad;
	logic           shed;
	logic [31:0]    wdiff;
	logic           due;
	logic [31:0]    age;
	logic           hit;
	logic           tick_done;
	logic           slot_done;
	logic [SIW-1:0] sidx_next;
	logic           out_free;
	logic [PW-1:0]  wp_inc;
	logic           we;
	logic [PW-1:0]  waddr;
	logic [40:0]    wdata;
	logic           stamp_we;
	logic [SIW-1:0] stamp_addr;
	logic           load;
	slaw_pkg::kind_t l_kind;
	logic [2:0]     l_slot;
	logic [7:0]     l_tag;
	logic [31:0]    l_age;
	logic           l_last;

	assign eff       = eff_of(slots_q);
	assign tm1       = top_q - 1'b1;
	assign pop_slot  = stack_q[tm1[SIW-1:0]];
	assign top_idx   = SIW'(top_q);
	assign rel_idx   = SIW'(slot_in_q);
	assign rel_bad   = ({29'd0, slot_in_q} >= 32'(eff)) || !leased_q[rel_idx];
	assign shed      = ((maxw_q != 7'd0) && (8'(wcnt_q) >= {1'b0, maxw_q}))
	                   || (32'(wcnt_q) >= 32'(WAIT_DEPTH));
	// deadline reached when the wrapped difference is non-negative
	assign wdiff     = now_q - rdata_q[39:8];
	assign due       = !rdata_q[40] && !wdiff[31];
	assign age       = now_q - stamp_q[sidx_q];
	assign hit       = leased_q[sidx_q] && (thr_q != 31'd0) && !rep_q[sidx_q]
	                   && (age >= {1'b0, thr_q});
	assign tick_done = (tidx_q == CW'(len_q - 1'b1));
	assign slot_done = (32'(sidx_q) == 32'(SLOTS - 1));
	assign sidx_next = slot_done ? '0 : sidx_q + 1'b1;
	assign out_free  = !ov_q || out_tready;
	assign wp_inc    = ptr_inc(wp_q);

	assign st.in_mode     = slaw_pkg::mode_t'(in_tuser);
	assign st.out_free    = out_free;
	assign st.wq_nonempty = (wcnt_q != '0);
	assign st.grant_pend  = grant_q;
	assign st.tick_done   = tick_done;
	assign st.due         = due;
	assign st.due_zero    = (due_q == '0);
	assign st.slot_done   = slot_done;
	assign st.hit         = hit;

	// queue write port: park at the tail, or compact kept entries during a tick
	always_comb begin
		we    = 1'b0;
		waddr = wp_q;
		wdata = rdata_q;
		if (op == slaw_pkg::OP_ACQ && top_q == '0 && !shed) begin
			we    = 1'b1;
			waddr = tail_q;
			wdata = {(tmo_q == 31'd0), now_q + {1'b0, tmo_q}, tag_in_q};
		end else if (op == slaw_pkg::OP_T2_EV && !due) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (op == slaw_pkg::OP_T_RD)
			rdata_q <= mem[rp_q];
		else if (op == slaw_pkg::OP_ACCEPT)
			rdata_q <= mem[head_q];
	end

	assign stamp_we   = (op == slaw_pkg::OP_ACQ && top_q != '0)
	                    || (op == slaw_pkg::OP_REL && !rel_bad && wcnt_q != '0);
	assign stamp_addr = (op == slaw_pkg::OP_ACQ) ? pop_slot : rel_idx;

	always_ff @(posedge clk) begin
		if (stamp_we) stamp_q[stamp_addr] <= now_q;
	end

	always_comb begin
		load   = 1'b0;
		l_kind = pkind_q;
		l_slot = pslot_q;
		l_tag  = ptag_q;
		l_age  = 32'd0;
		l_last = plast_q;
		case (op)
			slaw_pkg::OP_EMIT_PEND: load = 1'b1;
			slaw_pkg::OP_EMIT_GRANT: begin
				load   = 1'b1;
				l_kind = slaw_pkg::KIND_GRANTED;
				l_slot = gslot_q;
				l_tag  = gtag_q;
				l_last = 1'b1;
			end
			slaw_pkg::OP_T2_EV: begin
				load   = due;
				l_kind = slaw_pkg::KIND_TIMED_OUT;
				l_slot = 3'd0;
				l_tag  = rdata_q[7:0];
				l_last = (CW'(emit_q + 1'b1) == due_q);
			end
			slaw_pkg::OP_C2: begin
				load   = hit;
				l_kind = slaw_pkg::KIND_STUCK;
				l_slot = 3'(sidx_q);
				l_tag  = 8'd0;
				l_age  = age;
				l_last = 1'b0;
			end
			slaw_pkg::OP_C_STAT: begin
				load   = 1'b1;
				l_kind = slaw_pkg::KIND_STATUS;
				l_slot = 3'd0;
				l_tag  = 8'd0;
				l_age  = oldest_q;
				l_last = 1'b1;
			end
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= slaw_pkg::SLOTS_IN_USE_RST;
			tmo_q    <= slaw_pkg::ACQ_TIMEOUT_RST;
			maxw_q   <= slaw_pkg::MAX_WAITERS_RST;
			thr_q    <= slaw_pkg::STUCK_THRESH_RST;
			for (int i = 0; i < SLOTS; i++)
				stack_q[i] <= (i < int'(eff_of(slaw_pkg::SLOTS_IN_USE_RST))) ? SIW'(i) : '0;
			top_q    <= eff_of(slaw_pkg::SLOTS_IN_USE_RST);
			leased_q <= '0;
			rep_q    <= '0;
			cnt_q    <= 32'd0;
			now_q    <= 32'd0;
			head_q   <= '0;
			tail_q   <= '0;
			rp_q     <= '0;
			wp_q     <= '0;
			wcnt_q   <= '0;
			len_q    <= '0;
			tidx_q   <= '0;
			due_q    <= '0;
			emit_q   <= '0;
			sidx_q   <= '0;
			grant_q  <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (slaw_pkg::reg_idx_t'(cfg_index))
					slaw_pkg::REG_SLOTS_IN_USE: begin
						// rebuild the pool, parked requests are dropped
						slots_q <= cfg_data[3:0];
						for (int i = 0; i < SLOTS; i++)
							stack_q[i] <= (i < int'(eff_of(cfg_data[3:0]))) ? SIW'(i) : '0;
						top_q    <= eff_of(cfg_data[3:0]);
						leased_q <= '0;
						rep_q    <= '0;
						wcnt_q   <= '0;
						head_q   <= '0;
						tail_q   <= '0;
					end
					slaw_pkg::REG_ACQ_TIMEOUT:  tmo_q  <= cfg_data;
					slaw_pkg::REG_MAX_WAITERS:  maxw_q <= cfg_data[6:0];
					slaw_pkg::REG_STUCK_THRESH: thr_q  <= cfg_data;
					default: ;
				endcase
			end

			if (load)
				ov_q <= 1'b1;
			else if (out_tready)
				ov_q <= 1'b0;

			case (op)
				slaw_pkg::OP_ACCEPT: sidx_q <= '0;
				slaw_pkg::OP_ACQ: begin
					grant_q <= 1'b0;
					if (top_q != '0) begin
						top_q              <= tm1;
						leased_q[pop_slot] <= 1'b1;
						rep_q[pop_slot]    <= 1'b0;
					end else if (!shed) begin
						tail_q <= ptr_inc(tail_q);
						wcnt_q <= wcnt_q + 1'b1;
					end
				end
				slaw_pkg::OP_REL: begin
					grant_q <= !rel_bad && (wcnt_q != '0);
					if (!rel_bad) begin
						rep_q[rel_idx] <= 1'b0;
						if (wcnt_q != '0) begin
							// slot passes straight to the oldest waiter and stays leased
							head_q <= ptr_inc(head_q);
							wcnt_q <= wcnt_q - 1'b1;
						end else begin
							leased_q[rel_idx] <= 1'b0;
							if (32'(top_q) < 32'(SLOTS)) begin
								stack_q[top_idx] <= rel_idx;
								top_q            <= top_q + 1'b1;
							end
						end
					end
				end
				slaw_pkg::OP_T_INC: begin
					now_q  <= now_q + 32'd1;
					len_q  <= wcnt_q;
					tidx_q <= '0;
					rp_q   <= head_q;
					due_q  <= '0;
				end
				slaw_pkg::OP_T1_EV: begin
					if (due) due_q <= due_q + 1'b1;
					rp_q   <= ptr_inc(rp_q);
					tidx_q <= tidx_q + 1'b1;
				end
				slaw_pkg::OP_T2_START: begin
					wcnt_q <= len_q - due_q;
					rp_q   <= head_q;
					wp_q   <= head_q;
					tidx_q <= '0;
					emit_q <= '0;
				end
				slaw_pkg::OP_T2_EV: begin
					if (due)
						emit_q <= emit_q + 1'b1;
					else
						wp_q <= wp_inc;
					rp_q   <= ptr_inc(rp_q);
					tidx_q <= tidx_q + 1'b1;
					if (tick_done) tail_q <= due ? wp_q : wp_inc;
				end
				slaw_pkg::OP_C1: begin
					// first pass settles the counter before any report leaves
					if (hit && cnt_q != 32'hFFFF_FFFF) cnt_q <= cnt_q + 32'd1;
					sidx_q <= sidx_next;
				end
				slaw_pkg::OP_C2: begin
					if (hit) rep_q[sidx_q] <= 1'b1;
					sidx_q <= sidx_next;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			slaw_pkg::OP_ACCEPT: begin
				slot_in_q <= in_tdata[2:0];
				tag_in_q  <= in_tdata[10:3];
				oldest_q  <= 32'd0;
			end
			slaw_pkg::OP_ACQ: begin
				plast_q <= 1'b1;
				ptag_q  <= tag_in_q;
				if (top_q != '0) begin
					pkind_q <= slaw_pkg::KIND_GRANTED;
					pslot_q <= 3'(pop_slot);
				end else if (shed) begin
					pkind_q <= slaw_pkg::KIND_SHED;
					pslot_q <= 3'd0;
				end else begin
					pkind_q <= slaw_pkg::KIND_PARKED;
					pslot_q <= 3'd0;
				end
			end
			slaw_pkg::OP_REL: begin
				pkind_q <= rel_bad ? slaw_pkg::KIND_BAD_RELEASE : slaw_pkg::KIND_RELEASED;
				pslot_q <= slot_in_q;
				ptag_q  <= 8'd0;
				plast_q <= rel_bad || (wcnt_q == '0);
				gslot_q <= slot_in_q;
				gtag_q  <= rdata_q[7:0];
			end
			slaw_pkg::OP_C1: begin
				if (leased_q[sidx_q] && age > oldest_q) oldest_q <= age;
			end
			default: ;
		endcase
		if (load) begin
			okind_q <= l_kind;
			oslot_q <= l_slot;
			otag_q  <= l_tag;
			oage_q  <= l_age;
			ocnt_q  <= cnt_q;
			ofree_q <= 4'(top_q);
			owait_q <= 7'(wcnt_q);
			olast_q <= l_last;
		end
	end

	assign out_tvalid = ov_q;
	assign out_tdata  = {2'b00, owait_q, ofree_q, ocnt_q, oage_q, otag_q, oslot_q};
	assign out_tuser  = okind_q;
	assign out_tlast  = olast_q;

endmodule

[hdl/slot_lease_allocator_watchdog.sv]
// ----------------------------------------------------------------------------
// slot_lease_allocator_watchdog
// Lends slots from a free stack, parks overflow requests with a deadline and
// reports leases held too long.
// ----------------------------------------------------------------------------
// Usage: one transaction on the slave stream carries a request (tuser = mode:
// acquire, release, millisecond tick, stuck check); it yields zero or more
// results on the master stream, the final one flagged by tlast, the result
// kind in tuser. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle; writing the slot count rebuilds the pool.
// Timing: s_axis_tready is high only between transactions. Acquire and
// release pass an update step before their result; a hand-over adds a grant.
// A tick with nothing parked only advances the clock; else a pass counts the
// timed-out requests and, if any, another pass reports them and compacts the
// rest. A check scans all slots to settle the counter, again to report, then
// status. The waiter queue memory has a registered read port: read, then use.
// The output register holds a result while m_axis_tready is low; the next
// request is accepted meanwhile, and further results wait for the register.
// Reset empties the queue, clears all leases and fills the free stack; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module slot_lease_allocator_watchdog #(
	parameter int SLOTS      = slaw_pkg::SLOTS_DEF,
	parameter int WAIT_DEPTH = slaw_pkg::WAIT_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [slaw_pkg::IN_DW-1:0]  s_axis_tdata,  // slot[2:0], requester_tag[10:3]
	input  logic [slaw_pkg::IN_UW-1:0]  s_axis_tuser,  // mode[1:0]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// slot_res[2:0], requester_tag_res[10:3], age_ms[42:11], stuck_count[74:43],
	// free_count[78:75], waiting_count[85:79]
	output logic [slaw_pkg::OUT_DW-1:0] m_axis_tdata,
	output logic [slaw_pkg::OUT_UW-1:0] m_axis_tuser,  // kind[2:0]
	output logic                        m_axis_tlast,
	input  logic                        cfg_we,
	input  logic [slaw_pkg::CFG_IW-1:0] cfg_index,
	input  logic [slaw_pkg::CFG_DW-1:0] cfg_data
);

	slaw_pkg::dp_op_t     op;
	slaw_pkg::dp_status_t st;

	slaw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.op       (op)
	);

	slaw_dp #(
		.SLOTS      (SLOTS),
		.WAIT_DEPTH (WAIT_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.out_tlast  (m_axis_tlast)
	);

endmodule

[hdl/slaw_checker.sv]
// ----------------------------------------------------------------------------
// slaw_checker
// Port-level checks of the slot lease allocator, bound to the top level.
// ----------------------------------------------------------------------------
module slaw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [slaw_pkg::OUT_UW-1:0] m_axis_tuser,
	input logic                        m_axis_tlast
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// one transaction at a time: ready drops after an accepted request
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	// status closes every check
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == slaw_pkg::KIND_STATUS |-> m_axis_tlast)
		else $error("status without tlast");

	// stuck reports are always followed by status; shed and parked stand alone
	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tuser == slaw_pkg::KIND_STUCK && !m_axis_tlast)
		|| (m_axis_tuser == slaw_pkg::KIND_SHED && m_axis_tlast)
		|| (m_axis_tuser == slaw_pkg::KIND_PARKED && m_axis_tlast)
		|| (m_axis_tuser != slaw_pkg::KIND_STUCK && m_axis_tuser != slaw_pkg::KIND_SHED
		    && m_axis_tuser != slaw_pkg::KIND_PARKED))
		else $error("result kind and tlast disagree");

endmodule

bind slot_lease_allocator_watchdog slaw_checker u_slaw_checker (.*);

[test/slaw_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slaw_scoreboard
// Watches the request, result and register ports of the slot lease allocator,
// keeps its own copy of the pool, waiter queue and clock, and compares every
// result transaction field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module slaw_scoreboard (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [slaw_pkg::IN_DW-1:0]  s_axis_tdata,
	input  logic [slaw_pkg::IN_UW-1:0]  s_axis_tuser,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [slaw_pkg::OUT_DW-1:0] m_axis_tdata,
	input  logic [slaw_pkg::OUT_UW-1:0] m_axis_tuser,
	input  logic                        m_axis_tlast,
	input  logic                        cfg_we,
	input  logic [slaw_pkg::CFG_IW-1:0] cfg_index,
	input  logic [slaw_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        done,
	output int                          fails,
	output int                          outstanding
);

	typedef struct {
		slaw_pkg::kind_t kind;
		logic [2:0]  slot;
		logic [7:0]  tag;
		logic [31:0] age;
		logic [31:0] stuck;
		logic [3:0]  free;
		logic [6:0]  waiting;
		logic        last;
	} lease_res_t;

	typedef struct {
		logic [7:0]  tag;
		logic [31:0] deadline;
		logic        no_limit;
	} waiter_t;

	lease_res_t  due_results[$];
	waiter_t     waiters[$];

	logic [3:0]  slots_cfg;
	logic [30:0] timeout_cfg;
	logic [6:0]  max_wait_cfg;
	logic [30:0] thresh_cfg;
	logic [2:0]  free_stack[8];
	logic [3:0]  free_top;
	logic        leased[8];
	logic [31:0] stamp[8];
	logic        reported[8];
	logic [31:0] stuck_ctr;
	logic [31:0] now_ms;
	logic        done_seen;

	function automatic int eff_slots();
		return (slots_cfg < 8) ? int'(slots_cfg) : 8;
	endfunction

	task automatic rebuild_pool();
		int n;
		n = eff_slots();
		for (int i = 0; i < 8; i++) begin
			free_stack[i] = (i < n) ? 3'(i) : 3'd0;
			leased[i]     = 1'b0;
			stamp[i]      = '0;
			reported[i]   = 1'b0;
		end
		free_top = 4'(n);
		waiters.delete();
	endtask

	task automatic lend(input logic [2:0] s);
		leased[s]   = 1'b1;
		stamp[s]    = now_ms;
		reported[s] = 1'b0;
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fails++;
	endtask

	// works out the results of one request and queues them
	task automatic apply_request(input slaw_pkg::mode_t mode, input logic [2:0] slot,
			input logic [7:0] tag);
		lease_res_t fresh[$];
		lease_res_t r;
		waiter_t    w;
		waiter_t    kept[$];
		logic [31:0] age;
		logic [31:0] oldest;
		logic [2:0]  s;
		r = '{slaw_pkg::KIND_STATUS, 3'd0, 8'd0, 32'd0, 32'd0, 4'd0, 7'd0, 1'b0};
		case (mode)
			slaw_pkg::MODE_ACQUIRE: begin
				if (free_top > 0) begin
					free_top--;
					s = free_stack[free_top];
					lend(s);
					r.kind = slaw_pkg::KIND_GRANTED; r.slot = s; r.tag = tag;
				end else if ((max_wait_cfg > 0 && waiters.size() >= max_wait_cfg)
						|| waiters.size() >= 64) begin
					r.kind = slaw_pkg::KIND_SHED; r.tag = tag;
				end else begin
					w.tag      = tag;
					w.deadline = now_ms + {1'b0, timeout_cfg};
					w.no_limit = (timeout_cfg == 0);
					waiters.insert(waiters.size(), w);
					r.kind = slaw_pkg::KIND_PARKED; r.tag = tag;
				end
				fresh.insert(fresh.size(), r);
			end
			slaw_pkg::MODE_RELEASE: begin
				r.slot = slot;
				if (int'(slot) >= eff_slots() || !leased[slot]) begin
					r.kind = slaw_pkg::KIND_BAD_RELEASE;
					fresh.insert(fresh.size(), r);
				end else begin
					leased[slot]   = 1'b0;
					stamp[slot]    = '0;
					reported[slot] = 1'b0;
					r.kind = slaw_pkg::KIND_RELEASED;
					fresh.insert(fresh.size(), r);
					if (waiters.size() > 0) begin
						w = waiters.pop_front();
						lend(slot);
						r.kind = slaw_pkg::KIND_GRANTED; r.tag = w.tag;
						fresh.insert(fresh.size(), r);
					end else if (free_top < 8) begin
						free_stack[free_top] = slot;
						free_top++;
					end
				end
			end
			slaw_pkg::MODE_TICK: begin
				now_ms++;
				foreach (waiters[i]) begin
					if (!waiters[i].no_limit && (now_ms - waiters[i].deadline) < 32'h8000_0000)
							begin
						r.kind = slaw_pkg::KIND_TIMED_OUT; r.tag = waiters[i].tag;
						fresh.insert(fresh.size(), r);
					end else begin
						kept.insert(kept.size(), waiters[i]);
					end
				end
				waiters = kept;
			end
			default: begin
				oldest = '0;
				for (int i = 0; i < 8; i++) begin
					if (leased[i]) begin
						age = now_ms - stamp[i];
						if (thresh_cfg > 0 && !reported[i] && age >= {1'b0, thresh_cfg}) begin
							reported[i] = 1'b1;
							if (stuck_ctr != 32'hFFFF_FFFF)
								stuck_ctr++;
							r.kind = slaw_pkg::KIND_STUCK; r.slot = 3'(i); r.age = age;
							fresh.insert(fresh.size(), r);
						end
						if (age > oldest)
							oldest = age;
					end
				end
				r = '{slaw_pkg::KIND_STATUS, 3'd0, 8'd0, oldest, 32'd0, 4'd0, 7'd0, 1'b0};
				fresh.insert(fresh.size(), r);
			end
		endcase
		// the counts are those after the whole request
		foreach (fresh[k]) begin
			fresh[k].stuck   = stuck_ctr;
			fresh[k].free    = free_top;
			fresh[k].waiting = 7'(waiters.size());
			fresh[k].last    = (k == fresh.size() - 1);
			due_results.insert(due_results.size(), fresh[k]);
		end
	endtask

	task automatic check_result();
		lease_res_t e;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d", m_axis_tuser));
			return;
		end
		e = due_results.pop_front();
		if (m_axis_tuser != e.kind || m_axis_tdata[2:0] != e.slot
				|| m_axis_tdata[10:3] != e.tag || m_axis_tdata[42:11] != e.age
				|| m_axis_tdata[74:43] != e.stuck || m_axis_tdata[78:75] != e.free
				|| m_axis_tdata[85:79] != e.waiting || m_axis_tlast != e.last)
			report_mismatch($sformatf({"got kind %0d slot %0d tag %0h age %0d stuck %0d",
				" free %0d wait %0d last %0b, exp %s %0d %0h %0d %0d %0d %0d %0b"},
				m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[42:11],
				m_axis_tdata[74:43], m_axis_tdata[78:75], m_axis_tdata[85:79], m_axis_tlast,
				e.kind.name(), e.slot, e.tag, e.age, e.stuck, e.free, e.waiting, e.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg    = slaw_pkg::SLOTS_IN_USE_RST;
			timeout_cfg  = slaw_pkg::ACQ_TIMEOUT_RST;
			max_wait_cfg = slaw_pkg::MAX_WAITERS_RST;
			thresh_cfg   = slaw_pkg::STUCK_THRESH_RST;
			stuck_ctr    = '0;
			now_ms       = '0;
			fails        = 0;
			done_seen    = 1'b0;
			due_results.delete();
			rebuild_pool();
		end else begin
			if (cfg_we) begin
				case (slaw_pkg::reg_idx_t'(cfg_index))
					slaw_pkg::REG_SLOTS_IN_USE: begin
						slots_cfg = cfg_data[3:0];
						rebuild_pool();
					end
					slaw_pkg::REG_ACQ_TIMEOUT:  timeout_cfg  = cfg_data[30:0];
					slaw_pkg::REG_MAX_WAITERS:  max_wait_cfg = cfg_data[6:0];
					slaw_pkg::REG_STUCK_THRESH: thresh_cfg   = cfg_data[30:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_request(slaw_pkg::mode_t'(s_axis_tuser), s_axis_tdata[2:0],
					s_axis_tdata[10:3]);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (done && !done_seen) begin
				done_seen = 1'b1;
				foreach (due_results[i])
					report_mismatch($sformatf("missing result %s", due_results[i].kind.name()));
			end
		end
		outstanding = due_results.size();
	end

endmodule

[test/tb_slot_lease_allocator_watchdog.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_lease_allocator_watchdog
// Drives directed and random requests and register settings into the slot
// lease allocator under random idling on both streams and a long result stall;
// the scoreboard predicts and checks, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_slot_lease_allocator_watchdog;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 300;

	logic                        clk;
	logic                        arst_n;
	logic                        s_axis_tvalid;
	logic                        s_axis_tready;
	logic [slaw_pkg::IN_DW-1:0]  s_axis_tdata;
	logic [slaw_pkg::IN_UW-1:0]  s_axis_tuser;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready;
	logic [slaw_pkg::OUT_DW-1:0] m_axis_tdata;
	logic [slaw_pkg::OUT_UW-1:0] m_axis_tuser;
	logic                        m_axis_tlast;
	logic                        cfg_we;
	logic [slaw_pkg::CFG_IW-1:0] cfg_index;
	logic [slaw_pkg::CFG_DW-1:0] cfg_data;
	logic                        done;
	int                          fails;
	int                          outstanding;

	int  src_idle_pct;
	int  dst_idle_pct;
	int  hold_cnt;
	int  quiet_cycles;
	int  live_slots;
	bit  hold_request;

	slot_lease_allocator_watchdog dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	slaw_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .fails(fails), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random idling, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send(input slaw_pkg::mode_t mode, input logic [2:0] slot,
			input logic [7:0] tag);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {5'd0, tag, slot};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// waits for every result, then long enough for a silent tick scan
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input slaw_pkg::reg_idx_t idx,
			input logic [slaw_pkg::CFG_DW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == slaw_pkg::REG_SLOTS_IN_USE)
			live_slots = (value[3:0] < 8) ? int'(value[3:0]) : 8;
	endtask

	task automatic configure(input logic [3:0] slots, input logic [30:0] timeout,
			input logic [6:0] max_wait, input logic [30:0] thresh);
		write_reg(slaw_pkg::REG_SLOTS_IN_USE, {27'd0, slots});
		write_reg(slaw_pkg::REG_ACQ_TIMEOUT, timeout);
		write_reg(slaw_pkg::REG_MAX_WAITERS, {24'd0, max_wait});
		write_reg(slaw_pkg::REG_STUCK_THRESH, thresh);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(input int count, input int acquire_pct);
		int               pick;
		logic [2:0]       slot;
		slaw_pkg::mode_t  mode;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < acquire_pct)
				mode = slaw_pkg::MODE_ACQUIRE;
			else if (pick < acquire_pct + (100 - acquire_pct) * 45 / 100)
				mode = slaw_pkg::MODE_RELEASE;
			else if (pick < acquire_pct + (100 - acquire_pct) * 85 / 100)
				mode = slaw_pkg::MODE_TICK;
			else
				mode = slaw_pkg::MODE_CHECK;
			// mostly slots of the live pool so releases usually hit
			if (live_slots == 0 || $urandom_range(0, 99) < 20)
				slot = 3'($urandom_range(0, 7));
			else
				slot = 3'($urandom_range(0, live_slots - 1));
			send(mode, slot, 8'($urandom));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		done          = 1'b0;
		hold_request  = 1'b0;
		hold_cnt      = 0;
		quiet_cycles  = 0;
		live_slots    = 8;
		src_idle_pct  = 7;
		dst_idle_pct  = 86;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full pool at reset values, hand-over and bad releases
		for (int i = 0; i < 9; i++)
			send(slaw_pkg::MODE_ACQUIRE, 3'd0, 8'(i));
		send(slaw_pkg::MODE_CHECK, 3'd0, 8'd0);
		send(slaw_pkg::MODE_RELEASE, 3'd3, 8'd0);
		send(slaw_pkg::MODE_RELEASE, 3'd7, 8'd0);
		send(slaw_pkg::MODE_RELEASE, 3'd7, 8'd0);
		settle();

		// two slots, one waiter, short timeout, stuck after one tick
		configure(4'd2, 31'd2, 7'd1, 31'd1);
		send(slaw_pkg::MODE_ACQUIRE, 3'd0, 8'h00);
		send(slaw_pkg::MODE_ACQUIRE, 3'd0, 8'hFF);
		send(slaw_pkg::MODE_ACQUIRE, 3'd0, 8'h5A);
		send(slaw_pkg::MODE_ACQUIRE, 3'd0, 8'hA5);
		send(slaw_pkg::MODE_CHECK, 3'd0, 8'd0);
		send(slaw_pkg::MODE_TICK, 3'd0, 8'd0);
		send(slaw_pkg::MODE_CHECK, 3'd0, 8'd0);
		send(slaw_pkg::MODE_CHECK, 3'd0, 8'd0);
		send(slaw_pkg::MODE_RELEASE, 3'd1, 8'd0);
		send(slaw_pkg::MODE_RELEASE, 3'd7, 8'd0);
		send(slaw_pkg::MODE_ACQUIRE, 3'd0, 8'h11);
		send(slaw_pkg::MODE_TICK, 3'd0, 8'd0);
		send(slaw_pkg::MODE_TICK, 3'd0, 8'd0);
		send(slaw_pkg::MODE_RELEASE, 3'd0, 8'd0);
		send(slaw_pkg::MODE_RELEASE, 3'd0, 8'd0);
		settle();

		// empty pool: requests wait forever
		configure(4'd0, 31'd0, 7'd0, 31'h7FFF_FFFF);
		send(slaw_pkg::MODE_ACQUIRE, 3'd0, 8'h3C);
		send(slaw_pkg::MODE_RELEASE, 3'd0, 8'd0);
		send(slaw_pkg::MODE_TICK, 3'd0, 8'd0);
		send(slaw_pkg::MODE_CHECK, 3'd0, 8'd0);
		settle();

		configure(4'd3, 31'd5, 7'd4, 31'd3);
		random_items(45, 35);
		settle();

		src_idle_pct = 86;
		dst_idle_pct = 7;
		configure(4'd15, 31'h7FFF_FFFF, 7'd64, 31'h7FFF_FFFF);
		random_items(25, 35);
		settle();
		configure(4'd8, 31'd3, 7'd6, 31'd2);
		random_items(25, 40);
		settle();

		// one slot, queue limited by its depth only; results held back meanwhile
		src_idle_pct = 0;
		dst_idle_pct = 0;
		configure(4'd1, 31'd0, 7'd0, 31'd4);
		hold_request = 1'b1;
		random_items(70, 100);
		random_items(20, 30);
		settle();

		done <= 1'b1;
		repeat (2) @(posedge clk);
		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/slaw_pkg.sv
hdl/slaw_ctrl.sv
hdl/slaw_dp.sv
hdl/slot_lease_allocator_watchdog.sv
hdl/slaw_checker.sv
test/slaw_scoreboard.sv
test/tb_slot_lease_allocator_watchdog.sv
